[sv/lfuc_pkg.sv]
`timescale 1ns / 1ps
package lfuc_pkg;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CAP_W          = 5;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 72;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  // request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // register map (word index)
  localparam logic REG_CAPACITY = 1'b0;
endpackage

[sv/lfu_cache_lru_tiebreak.sv]
`timescale 1ns / 1ps
// a hit or a put makes two sweeps of the entry memory (a lookup sweep and a
//   read-modify-write sweep), a get miss only the lookup sweep; a new request is
//   taken only in idle with no result pending, so one request is handled at a time
// reset: synchronous, clears valid bits, fill count, state and output valid;
//   capacity returns to 16, the entry memory itself is not cleared
module lfu_cache_lru_tiebreak
  import lfuc_pkg::*;
#(
  parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lfuc_pkg::IN_DATA_W-1:0]   s_tdata,   // key, write_value
  input  logic                             s_tuser,   // req_type
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lfuc_pkg::OUT_DATA_W-1:0]  m_tdata,   // hit, read_value, evicted, evicted_key
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int FILL_BITS = $clog2(ENTRIES + 1);
  localparam int CW        = (FILL_BITS > CAP_W) ? FILL_BITS : CAP_W;
  localparam int REC_W     = KEY_W + VAL_W + COUNT_BITS + RANK_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;

  logic [2:0]            state;
  logic [CAP_W-1:0]      capacity;
  logic [ENTRIES-1:0]    valid;
  logic [FILL_BITS-1:0]  fill;

  // latched request
  logic                  req_put;
  key_t                  req_key;
  val_t                  req_val;

  // sweep control: cnt issues reads, proc_* is the entry whose data is back
  logic [IDX_BITS:0]     cnt;
  logic                  proc_en;
  logic [IDX_BITS-1:0]   proc_idx;

  // lookup results
  logic                  found;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [RANK_BITS-1:0]  hit_rank;
  val_t                  hit_val;
  logic                  have_v;
  logic [IDX_BITS-1:0]   v_idx;
  logic [COUNT_BITS-1:0] v_cnt;
  logic [RANK_BITS-1:0]  v_rank;
  key_t                  v_key;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;

  // update plan
  logic [IDX_BITS-1:0]   target;
  logic [RANK_BITS-1:0]  thr;
  logic                  age_all;
  logic                  insert;
  logic                  evict;

  // result register
  logic                  res_hit;
  val_t                  res_rval;
  logic                  res_evicted;
  key_t                  res_ekey;

  // memory
  logic                  mem_we;
  logic [REC_W-1:0]      mem_wdata;
  logic [REC_W-1:0]      rd_data;
  key_t                  d_key;
  val_t                  d_val;
  logic [COUNT_BITS-1:0] d_cnt;
  logic [RANK_BITS-1:0]  d_rank;

  logic [CW-1:0]         cap_eff;
  logic                  full;
  logic                  sweep_done;
  logic                  p_valid;

  lfuc_mem #(.DEPTH(ENTRIES), .WIDTH(REC_W)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (proc_idx),
    .wr_data (mem_wdata),
    .rd_addr (cnt[IDX_BITS-1:0]),
    .rd_data (rd_data)
  );

  assign d_rank = rd_data[RANK_BITS-1:0];
  assign d_cnt  = rd_data[RANK_BITS +: COUNT_BITS];
  assign d_val  = rd_data[RANK_BITS+COUNT_BITS +: VAL_W];
  assign d_key  = rd_data[RANK_BITS+COUNT_BITS+VAL_W +: KEY_W];
  assign p_valid = valid[proc_idx];

  // capacity zero acts as one, above ENTRIES as ENTRIES
  always_comb begin
    cap_eff = CW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end
  assign full = CW'(fill) >= cap_eff;

  assign sweep_done = (cnt == (IDX_BITS+1)'(ENTRIES)) && !proc_en;

  // write-back of one entry during the update sweep
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data;
    if (state == ST_UPDATE && proc_en) begin
      if (proc_idx == target) begin
        mem_we = 1'b1;
        if (insert) begin
          mem_wdata = {req_key, req_val, COUNT_BITS'(1), RANK_BITS'(0)};
        end else begin
          mem_wdata = {d_key, (req_put ? req_val : d_val),
                       ((d_cnt == '1) ? d_cnt : d_cnt + COUNT_BITS'(1)), RANK_BITS'(0)};
        end
      end else if (p_valid && (age_all || d_rank < thr)) begin
        mem_we    = 1'b1;
        mem_wdata = {d_key, d_val, d_cnt, d_rank + RANK_BITS'(1)};
      end
    end
  end

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign m_tdata  = {6'b0, res_ekey, res_evicted, res_rval, res_hit};

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (psel && penable && pwrite && paddr == {REG_CAPACITY, 2'b00}) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
      proc_en  <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            req_put    <= s_tuser;
            req_key    <= s_tdata[KEY_W-1:0];
            req_val    <= s_tdata[KEY_W +: VAL_W];
            found      <= 1'b0;
            have_v     <= 1'b0;
            free_found <= 1'b0;
            cnt        <= '0;
            proc_en    <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue the next read, look at the entry read last cycle
          if (cnt != (IDX_BITS+1)'(ENTRIES)) begin
            proc_en  <= 1'b1;
            proc_idx <= cnt[IDX_BITS-1:0];
            cnt      <= cnt + (IDX_BITS+1)'(1);
          end else begin
            proc_en <= 1'b0;
          end
          if (proc_en) begin
            if (p_valid && !found && d_key == req_key) begin
              found    <= 1'b1;
              hit_idx  <= proc_idx;
              hit_rank <= d_rank;
              hit_val  <= d_val;
            end
            // victim: lowest count, then oldest
            if (p_valid && (!have_v || d_cnt < v_cnt ||
                            (d_cnt == v_cnt && d_rank > v_rank))) begin
              have_v <= 1'b1;
              v_idx  <= proc_idx;
              v_cnt  <= d_cnt;
              v_rank <= d_rank;
              v_key  <= d_key;
            end
            if (!p_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
          end
          if (sweep_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt     <= '0;
          proc_en <= 1'b0;
          if (found) begin
            res_hit     <= 1'b1;
            res_rval    <= req_put ? '0 : hit_val;
            res_evicted <= 1'b0;
            res_ekey    <= '0;
            target      <= hit_idx;
            thr         <= hit_rank;
            insert      <= 1'b0;
            evict       <= 1'b0;
            age_all     <= 1'b0;
            state       <= ST_UPDATE;
          end else if (req_put == REQ_GET) begin
            res_hit     <= 1'b0;
            res_rval    <= '0;
            res_evicted <= 1'b0;
            res_ekey    <= '0;
            m_tvalid    <= 1'b1;
            state       <= ST_IDLE;
          end else if (full && have_v) begin
            // evict then insert in place: entries newer than the victim age by one
            res_hit     <= 1'b0;
            res_rval    <= '0;
            res_evicted <= 1'b1;
            res_ekey    <= v_key;
            target      <= v_idx;
            thr         <= v_rank;
            insert      <= 1'b1;
            evict       <= 1'b1;
            age_all     <= 1'b0;
            state       <= ST_UPDATE;
          end else if (free_found) begin
            res_hit     <= 1'b0;
            res_rval    <= '0;
            res_evicted <= 1'b0;
            res_ekey    <= '0;
            target      <= free_idx;
            insert      <= 1'b1;
            evict       <= 1'b0;
            age_all     <= 1'b1;
            state       <= ST_UPDATE;
          end else begin
            res_hit     <= 1'b0;
            res_rval    <= '0;
            res_evicted <= 1'b0;
            res_ekey    <= '0;
            m_tvalid    <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_UPDATE: begin
          if (cnt != (IDX_BITS+1)'(ENTRIES)) begin
            proc_en  <= 1'b1;
            proc_idx <= cnt[IDX_BITS-1:0];
            cnt      <= cnt + (IDX_BITS+1)'(1);
          end else begin
            proc_en <= 1'b0;
          end
          if (sweep_done) begin
            if (insert) begin
              valid[target] <= 1'b1;
              if (!evict) begin
                fill <= fill + FILL_BITS'(1);
              end
            end
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // fill count tracks the valid bits
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(fill))
    else $error("fill count out of step with valid bits");

  // a result never reports both a hit and an eviction
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
    else $error("hit and eviction in one result");

  // the entry memory is only written during the update sweep
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_UPDATE))
    else $error("memory write outside update");

  // a new request is only taken with the result slot empty
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SCAN && !m_tvalid))
    else $error("request overlaps a pending result");
endmodule

[sv/lfuc_mem.sv]
`timescale 1ns / 1ps
module lfuc_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
